// ===== design/vfld_pkg.sv =====
// shared types, codes and element attribute helpers for the vertex format layout decoder
package vfld_pkg;

  // element kinds in emission order
  typedef enum logic [2:0] {
    K_POS    = 3'd0,
    K_BLENDW = 3'd1,
    K_BLENDI = 3'd2,
    K_NORMAL = 3'd3,
    K_PSIZE  = 3'd4,
    K_DIFF   = 3'd5,
    K_SPEC   = 3'd6,
    K_TEX    = 3'd7
  } kind_e;

  localparam int unsigned NumKinds = 8;

  // semantic codes
  localparam logic [2:0] SEM_POS    = 3'd0;
  localparam logic [2:0] SEM_POST   = 3'd1;
  localparam logic [2:0] SEM_BLENDW = 3'd2;
  localparam logic [2:0] SEM_BLENDI = 3'd3;
  localparam logic [2:0] SEM_NORMAL = 3'd4;
  localparam logic [2:0] SEM_PSIZE  = 3'd5;
  localparam logic [2:0] SEM_COLOR  = 3'd6;
  localparam logic [2:0] SEM_TEX    = 3'd7;

  // element format codes
  localparam logic [2:0] FMT_F4    = 3'd0;
  localparam logic [2:0] FMT_F3    = 3'd1;
  localparam logic [2:0] FMT_F1    = 3'd2;
  localparam logic [2:0] FMT_U8X4  = 3'd3;
  localparam logic [2:0] FMT_UN8X4 = 3'd4;
  localparam logic [2:0] FMT_F2    = 3'd5;

  // format code fields
  localparam logic [31:0] PosMask     = 32'h0000_400E;
  localparam logic [31:0] PosXyz      = 32'h0000_0002;
  localparam logic [31:0] PosXyzrhw   = 32'h0000_0004;
  localparam int unsigned BitNormal   = 4;
  localparam int unsigned BitPsize    = 5;
  localparam int unsigned BitDiffuse  = 6;
  localparam int unsigned BitSpecular = 7;
  localparam int unsigned TexLsb      = 8;
  localparam int unsigned TexMsb      = 11;

  typedef struct packed {
    logic       element_valid;
    logic [2:0] semantic;
    logic [3:0] semantic_index;
    logic [2:0] element_format;
    logic [7:0] byte_offset;
    logic [4:0] attribute_location;
    logic [7:0] vertex_stride;
    logic       last_element;
  } result_t;

  typedef struct packed {
    logic load;   // take a new format code
    logic step;   // emit one result into the output register
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic last;       // the result emitted on step is the final one
  } status_t;

  typedef struct packed {
    logic [2:0] sem;
    logic [2:0] fmt;
    logic [4:0] size;
  } attr_t;

  function automatic attr_t kind_attr(kind_e k, logic xyzrhw);
    attr_t a;
    case (k)
      K_POS: begin
        a.sem  = xyzrhw ? SEM_POST : SEM_POS;
        a.fmt  = xyzrhw ? FMT_F4 : FMT_F3;
        a.size = xyzrhw ? 5'd16 : 5'd12;
      end
      K_BLENDW: a = '{sem: SEM_BLENDW, fmt: FMT_F1,    size: 5'd4};
      K_BLENDI: a = '{sem: SEM_BLENDI, fmt: FMT_U8X4,  size: 5'd4};
      K_NORMAL: a = '{sem: SEM_NORMAL, fmt: FMT_F3,    size: 5'd12};
      K_PSIZE:  a = '{sem: SEM_PSIZE,  fmt: FMT_F1,    size: 5'd4};
      K_DIFF:   a = '{sem: SEM_COLOR,  fmt: FMT_UN8X4, size: 5'd4};
      K_SPEC:   a = '{sem: SEM_COLOR,  fmt: FMT_UN8X4, size: 5'd4};
      K_TEX:    a = '{sem: SEM_TEX,    fmt: FMT_F2,    size: 5'd8};
      default:  a = '{sem: SEM_POS,    fmt: FMT_F4,    size: 5'd0};
    endcase
    return a;
  endfunction

  // lowest pending kind
  function automatic kind_e first_kind(logic [NumKinds-1:0] pend);
    kind_e k;
    k = K_POS;
    for (int i = NumKinds - 1; i >= 0; i--) begin
      if (pend[i]) k = kind_e'(3'(i));
    end
    return k;
  endfunction

endpackage

// ===== design/vfld_if.sv =====
// valid/ready channel interfaces for format codes and layout results
interface vfld_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] format_code;

  modport source (output valid, output format_code, input ready);
  modport sink   (input valid, input format_code, output ready);
endinterface

interface vfld_out_if import vfld_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== design/vertex_format_layout_decoder.sv =====
// top level of the vertex format layout decoder: controller, datapath and assertions
// throughput: one result per cycle while the output is not held back, n results per code
//   (n = 1..26, one for an empty code); the next code is accepted the cycle after the last
//   result enters the output register, as the controller walks a code one element at a time
// reset: rst_ni clears controller state and the output valid; payload registers are not reset
module vertex_format_layout_decoder import vfld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  vfld_in_if.sink    in_i,
  vfld_out_if.source out_o
);

  cmd_t    cmd;
  status_t sts;

  // controller: idle waits for a code, walk steps one element per free output slot
  vfld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: decodes the code on load, walks the element list and holds the output item
  vfld_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .format_code_i (in_i.format_code),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .result_o      (out_o.result)
  );

`ifndef SYNTHESIS
  // load and step are exclusive
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.step)) else $error("load and step asserted together");

  // a step never overwrites an item that is still waiting
  a_step_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> sts.slot_free) else $error("step into occupied output register");

  // a code is walked before the next one is taken
  a_one_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("input ready right after accept");

  // the empty marker is always the final item
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.result.element_valid) |-> out_o.result.last_element)
    else $error("empty item without last mark");
`endif

endmodule

// ===== design/vfld_ctrl.sv =====
// controller state machine: sequences load and per-element steps
module vfld_ctrl import vfld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.step = sts_i.slot_free;
        if (sts_i.slot_free && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/vfld_dp.sv =====
// datapath: format decode, element walk registers and output register
module vfld_dp import vfld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] format_code_i,
  input  cmd_t        cmd_i,
  output status_t     sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output result_t     result_o
);

  // walk state
  kind_e                kind_q;
  logic [3:0]           idx_q;
  logic [NumKinds-1:0]  pend_q;
  logic [7:0]           off_q;
  logic [4:0]           loc_q;
  logic [7:0]           stride_q;
  logic [2:0]           wcnt_q;
  logic [3:0]           tcnt_q;
  logic                 xyzrhw_q;
  logic                 out_valid_q;
  result_t              res_q;

  // decode of the incoming code
  logic [31:0]          pos;
  logic                 is_xyz, is_xyzrhw, is_blend;
  logic [2:0]           wcnt;
  logic [3:0]           tcnt;
  logic [NumKinds-1:0]  present;
  logic [7:0]           stride;

  always_comb begin
    pos       = format_code_i & PosMask;
    is_xyz    = (pos == PosXyz);
    is_xyzrhw = (pos == PosXyzrhw);
    // xyz plus 1..5 blend weights
    is_blend  = !pos[14] && (pos[3:1] >= 3'd3);
    wcnt      = is_blend ? (pos[3:1] - 3'd2) : 3'd0;
    tcnt      = format_code_i[TexMsb:TexLsb];
    present   = {tcnt != 4'd0, format_code_i[BitSpecular], format_code_i[BitDiffuse],
                 format_code_i[BitPsize], format_code_i[BitNormal],
                 wcnt != 3'd0, wcnt != 3'd0, is_xyz | is_xyzrhw | is_blend};
    stride    = ((is_xyz || is_blend) ? 8'd12 : (is_xyzrhw ? 8'd16 : 8'd0))
              + {3'd0, wcnt, 2'b00}
              + ((wcnt != 3'd0) ? 8'd4 : 8'd0)
              + (format_code_i[BitNormal]   ? 8'd12 : 8'd0)
              + (format_code_i[BitPsize]    ? 8'd4  : 8'd0)
              + (format_code_i[BitDiffuse]  ? 8'd4  : 8'd0)
              + (format_code_i[BitSpecular] ? 8'd4  : 8'd0)
              + {1'b0, tcnt, 3'b000};
  end

  // advance of the walk
  attr_t               attr;
  logic [3:0]          idx_nxt;
  logic                kind_done;
  logic [NumKinds-1:0] rem;
  logic                pend_empty;
  logic                last;
  result_t             res_d;

  always_comb begin
    attr       = kind_attr(kind_q, xyzrhw_q);
    idx_nxt    = idx_q + 4'd1;
    kind_done  = !((kind_q == K_BLENDW) && (idx_nxt < {1'b0, wcnt_q}))
              && !((kind_q == K_TEX) && (idx_nxt < tcnt_q));
    rem        = kind_done ? (pend_q & ~(NumKinds'(1) << kind_q)) : pend_q;
    pend_empty = (pend_q == '0);
    last       = pend_empty || (rem == '0);

    if (pend_empty) begin
      res_d              = '0;
      res_d.last_element = 1'b1;
    end else begin
      res_d.element_valid      = 1'b1;
      res_d.semantic           = attr.sem;
      res_d.semantic_index     = (kind_q == K_SPEC) ? 4'd1 : idx_q;
      res_d.element_format     = attr.fmt;
      res_d.byte_offset        = off_q;
      res_d.attribute_location = loc_q;
      res_d.vertex_stride      = stride_q;
      res_d.last_element       = last;
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last      = last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= first_kind(present);
      idx_q    <= '0;
      pend_q   <= present;
      off_q    <= '0;
      loc_q    <= '0;
      stride_q <= stride;
      wcnt_q   <= wcnt;
      tcnt_q   <= tcnt;
      xyzrhw_q <= is_xyzrhw;
    end else if (cmd_i.step) begin
      kind_q <= kind_done ? first_kind(rem) : kind_q;
      idx_q  <= kind_done ? 4'd0 : idx_nxt;
      pend_q <= rem;
      off_q  <= off_q + {3'd0, attr.size};
      loc_q  <= loc_q + 5'd1;
    end
    if (cmd_i.step) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the vertex format layout decoder
`timescale 1ns / 100ps

module tb_top import vfld_pkg::*; ();

  // run shape
  localparam int unsigned RandomCodes = 300;
  localparam int unsigned IdlePercent = 24;
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned DrainCycles = 20;    // plenty of margin after the drain
  localparam int unsigned StallLimit  = 2000;  // cycles with no format code taken
  localparam int unsigned MaxElements = 26;

  // bit 14 belongs to the position field but never forms a known type
  localparam int unsigned BitPosExt = 14;

  // element sizes in bytes
  localparam int unsigned SizeF4  = 16;
  localparam int unsigned SizeF3  = 12;
  localparam int unsigned SizeF2  = 8;
  localparam int unsigned SizeF1  = 4;
  localparam int unsigned SizeU8  = 4;

  // layout prediction and in-order comparison of results
  class layout_scoreboard;
    result_t     pending[$];
    int unsigned errors;
    int unsigned codes_seen;
    int unsigned results_seen;
    int unsigned empty_codes;
    int unsigned full_codes;

    function result_t elem(logic [2:0] sem, int unsigned idx, logic [2:0] fmt,
                           int unsigned off, int unsigned loc);
      result_t r;
      r = '0;
      r.element_valid      = 1'b1;
      r.semantic           = sem;
      r.semantic_index     = 4'(idx);
      r.element_format     = fmt;
      r.byte_offset        = 8'(off);
      r.attribute_location = 5'(loc);
      return r;
    endfunction

    function void note_code(logic [31:0] code);
      result_t     layout[$];
      result_t     r;
      logic [31:0] pos;
      int unsigned off;
      int unsigned weights;
      int unsigned texcount;
      codes_seen++;
      pos      = code & PosMask;
      off      = 0;
      weights  = 0;
      texcount = code[TexMsb:TexLsb];
      if (pos == PosXyz) begin
        layout = {layout, elem(SEM_POS, 0, FMT_F3, off, layout.size())};
        off += SizeF3;
      end else if (pos == PosXyzrhw) begin
        layout = {layout, elem(SEM_POST, 0, FMT_F4, off, layout.size())};
        off += SizeF4;
      end else if (pos[31:4] == '0 && pos[3:1] >= 3'd3) begin
        // xyz plus one to five blend weights
        layout = {layout, elem(SEM_POS, 0, FMT_F3, off, layout.size())};
        off += SizeF3;
        weights = pos[3:1] - 3'd2;
      end
      for (int unsigned i = 0; i < weights; i++) begin
        layout = {layout, elem(SEM_BLENDW, i, FMT_F1, off, layout.size())};
        off += SizeF1;
      end
      if (weights > 0) begin
        layout = {layout, elem(SEM_BLENDI, 0, FMT_U8X4, off, layout.size())};
        off += SizeU8;
      end
      if (code[BitNormal]) begin
        layout = {layout, elem(SEM_NORMAL, 0, FMT_F3, off, layout.size())};
        off += SizeF3;
      end
      if (code[BitPsize]) begin
        layout = {layout, elem(SEM_PSIZE, 0, FMT_F1, off, layout.size())};
        off += SizeF1;
      end
      if (code[BitDiffuse]) begin
        layout = {layout, elem(SEM_COLOR, 0, FMT_UN8X4, off, layout.size())};
        off += SizeU8;
      end
      if (code[BitSpecular]) begin
        layout = {layout, elem(SEM_COLOR, 1, FMT_UN8X4, off, layout.size())};
        off += SizeU8;
      end
      // texture coordinates are always float2
      for (int unsigned i = 0; i < texcount; i++) begin
        layout = {layout, elem(SEM_TEX, i, FMT_F2, off, layout.size())};
        off += SizeF2;
      end

      if (layout.size() == 0) begin
        r = '0;
        r.last_element = 1'b1;
        pending = {pending, r};
        empty_codes++;
      end else begin
        foreach (layout[k]) layout[k].vertex_stride = 8'(off);
        layout[layout.size() - 1].last_element = 1'b1;
        if (layout.size() == MaxElements) full_codes++;
        pending = {pending, layout};
      end
    endfunction

    function void field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no element waiting: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      field_ok("element_valid", want.element_valid, got.element_valid);
      field_ok("semantic", want.semantic, got.semantic);
      field_ok("semantic_index", want.semantic_index, got.semantic_index);
      field_ok("element_format", want.element_format, got.element_format);
      field_ok("byte_offset", want.byte_offset, got.byte_offset);
      field_ok("attribute_location", want.attribute_location, got.attribute_location);
      field_ok("vertex_stride", want.vertex_stride, got.vertex_stride);
      field_ok("last_element", want.last_element, got.last_element);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;     // no idling on either side while set
  bit   hold_req;   // asks the receiver for one long hold-off
  int unsigned quiet_cycles;

  layout_scoreboard layouts = new();

  vfld_in_if  code_ch ();
  vfld_out_if layout_ch ();

  vertex_format_layout_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (code_ch),
    .out_o  (layout_ch)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // handshakes are sampled at the rising edge; the code is noted before the
  // result check since a result never comes in the same cycle as its code
  always @(posedge clk_i) begin
    if (code_ch.valid && code_ch.ready) layouts.note_code(code_ch.format_code);
    if (layout_ch.valid && layout_ch.ready) layouts.check_result(layout_ch.result);
  end

  // watchdog: ends the run when no format code is taken for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(code_ch.valid && code_ch.ready))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no format code taken for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    layout_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        layout_ch.ready <= 1'b0;
        // the sender keeps offering codes meanwhile, so the block fills up
        repeat (HoldCycles) @(negedge clk_i);
      end
      layout_ch.ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  // offers one format code, entered and left at a falling edge
  task automatic send_code(input logic [31:0] code, input bit may_idle);
    while (may_idle && $urandom_range(99) < IdlePercent) begin
      code_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    code_ch.valid       <= 1'b1;
    code_ch.format_code <= code;
    @(posedge clk_i);
    while (!code_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender stops and waits for every expected element
  task automatic drain_layouts();
    code_ch.valid <= 1'b0;
    do @(negedge clk_i); while (layouts.pending.size() != 0);
  endtask

  initial begin
    logic [31:0] directed[$] = '{
      32'h0000_0000,   // nothing at all, empty result
      32'hFFFF_FFFF,   // every bit set, unknown position
      32'h0000_0002,   // xyz
      32'h0000_0004,   // transformed xyzw
      32'h0000_0006,   // xyz and one blend weight
      32'h0000_0008,
      32'h0000_000A,
      32'h0000_000C,
      32'h0000_000E,   // five blend weights
      32'h0000_4002,   // xyzw is treated as unknown
      32'h0000_400E,   // unknown position, nothing else
      32'h0000_0010,   // normal alone
      32'h0000_0020,   // point size alone
      32'h0000_0040,   // diffuse alone
      32'h0000_0080,   // specular alone
      32'h0000_0F00,   // fifteen texcoords only
      32'h0000_0FFE,   // longest layout, 26 elements
      32'hFFFF_BFFF,   // longest layout with ignored bits set
      32'hFFFF_B001,   // ignored bits only, empty
      32'h00FF_0302,   // texcoord size bits ignored
      32'h0000_0001,   // low ignored bit only
      32'h0000_0104    // transformed position with one texcoord
    };
    logic [31:0] code;
    int unsigned pick;

    rst_ni              = 1'b0;
    steady              = 1'b0;
    hold_req            = 1'b0;
    quiet_cycles        = 0;
    code_ch.valid       = 1'b0;
    code_ch.format_code = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_code(directed[i], 1'b1);

    for (int unsigned i = 0; i < RandomCodes; i++) begin
      // a stretch with no idling on either side
      steady = (i >= 60 && i < 120);
      if (i == 150) hold_req = 1'b1;
      if (i == 220) drain_layouts();
      pick = $urandom_range(99);
      code = $urandom();
      if (pick < 70) begin
        // known position type, random flags and texcount
        code[BitPosExt] = 1'b0;
        code[3:1]       = 3'($urandom_range(7, 1));
      end else if (pick < 85) begin
        code[BitPosExt] = 1'b1;
      end else if (pick < 93) begin
        // no position, no flags, no texcoords
        code[11:1] = '0;
      end
      send_code(code, !steady);
    end
    steady = 1'b0;

    drain_layouts();
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d format codes: %0d empty, %0d with the full 26 elements",
             layouts.codes_seen, layouts.empty_codes, layouts.full_codes);
    $display("compared %0d layout results, %0d still waiting, %0d mismatches",
             layouts.results_seen, layouts.pending.size(), layouts.errors);
    if (layouts.errors == 0 && layouts.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
